// File: sv/probabilistic_fault_injector_defines.svh
// Assertion macros shared by the fault injector RTL.
`ifndef PROBABILISTIC_FAULT_INJECTOR_DEFINES_SVH
`define PROBABILISTIC_FAULT_INJECTOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define PFI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define PFI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/pfi_pkg.sv
// Types, constants and helper functions of the probabilistic fault injector.
package pfi_pkg;

  localparam int PFI_NUM_POINTS = 12;
  localparam int MAX_POINTS     = 16;
  localparam int PCT_W          = 7;
  localparam int CNT_W          = 32;

  localparam logic [30:0] LCG_MUL  = 31'd1103515245;
  localparam logic [30:0] LCG_ADD  = 31'd12345;
  localparam int          PCT_BASE = 100;

  // seed div 100 as (seed * RECIP_100) >> RECIP_SHIFT, exact for 31-bit seeds
  localparam logic [30:0] RECIP_100   = 31'd1374389535;
  localparam int          RECIP_SHIFT = 37;
  localparam int          MOD_QW      = 25;

  // shared divider widths
  localparam int DIV_DW = 39;  // holds failures*100
  localparam int DIV_QW = 8;   // rate quotient, saturates to all ones on overflow
  localparam int DIV_TW = 5;
  localparam logic [DIV_TW-1:0] RATE_TOP = DIV_TW'(7);

  // input modes
  localparam logic [1:0] MODE_CHECK   = 2'd0;
  localparam logic [1:0] MODE_STATS   = 2'd1;
  localparam logic [1:0] MODE_CLR_ONE = 2'd2;
  localparam logic [1:0] MODE_CLR_ALL = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_ENABLE  = 2'd0;
  localparam logic [1:0] CFG_PROB_LO = 2'd1;
  localparam logic [1:0] CFG_PROB_HI = 2'd2;

  typedef struct packed {
    logic [1:0] mode;
    logic [3:0] point_index;
  } pfi_in_t;

  typedef struct packed {
    logic             status;
    logic             fail_now;
    logic [CNT_W-1:0] calls_seen;
    logic [CNT_W-1:0] failures_seen;
    logic [PCT_W-1:0] failure_rate;
    logic [PCT_W-1:0] point_probability;
    logic             point_enabled;
  } pfi_out_t;

  typedef struct packed {
    logic              start;
    logic [DIV_TW-1:0] top;
    logic [DIV_DW-1:0] dividend;
    logic [CNT_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_QW-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_LCG,
    S_MOD,
    S_RATE0,
    S_RATE,
    S_DONE
  } pfi_state_t;

  function automatic logic [31:0] seed_init(input logic [3:0] k);
    logic [31:0] v;
    case (k)
      4'd0:    v = 32'h12345678;
      4'd1:    v = 32'h23456789;
      4'd2:    v = 32'h3456789A;
      4'd3:    v = 32'h456789AB;
      4'd4:    v = 32'h56789ABC;
      4'd5:    v = 32'h6789ABCD;
      4'd6:    v = 32'h789ABCDE;
      4'd7:    v = 32'h89ABCDEF;
      4'd8:    v = 32'h9ABCDEF0;
      4'd9:    v = 32'hABCDEF01;
      4'd10:   v = 32'hBCDEF012;
      4'd11:   v = 32'hCDEF0123;
      4'd12:   v = 32'hDEF01234;
      4'd13:   v = 32'hEF012345;
      4'd14:   v = 32'hF0123456;
      default: v = 32'h01234567;
    endcase
    return v;
  endfunction

  // 31-bit LCG step; only the low 31 bits of the product survive
  function automatic logic [30:0] lcg_next(input logic [31:0] s);
    logic [30:0] p;
    p = s[30:0] * LCG_MUL + LCG_ADD;
    return p;
  endfunction

endpackage

// File: sv/probabilistic_fault_injector.sv
// Probabilistic fault injector: point table, sequencer and output register.
// Each request selects one fault point, and the block stalls new requests until it is
// through with it. A check on an enabled point with a nonzero percentage runs the
// 31-bit LCG multiply, then the reciprocal multiply that gives seed div 100, then the
// remainder compare, then 8 compare-subtract steps of the shared divider for the failure
// rate, and then waits to see the divider finish. Other requests skip the LCG and
// remainder steps; a point with no calls also skips the divider, and an out-of-range index
// goes straight to the result. A finished result sits in an output register, so the next
// request is taken while it waits; that request holds in S_DONE until the
// register is free. Configuration writes are taken in every cycle.
`include "probabilistic_fault_injector_defines.svh"

module probabilistic_fault_injector
  import pfi_pkg::*;
#(
  parameter int NUM_POINTS = PFI_NUM_POINTS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  pfi_in_t     req_data,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output pfi_out_t    rsp_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [55:0] cfg_data
);

  localparam int IW = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;

  pfi_state_t state, state_next;

  logic        enable;
  logic [55:0] prob_lo;
  logic [55:0] prob_hi;

  logic [31:0]      seeds [NUM_POINTS];
  logic [CNT_W-1:0] calls [NUM_POINTS];
  logic [CNT_W-1:0] fails [NUM_POINTS];

  logic [1:0]       mode_r;
  logic [3:0]       idx_r;
  logic             fail_r;
  logic [PCT_W-1:0] rate_r;
  logic [30:0]      lcg_val;
  logic [MOD_QW-1:0] mod_q;

  logic             found;
  logic [IW-1:0]    sel;
  logic [PCT_W-1:0] pct;
  logic [31:0]      seed_rd;
  logic [CNT_W-1:0] calls_rd;
  logic [CNT_W-1:0] fails_rd;
  logic [30:0]      seed_next;
  logic [61:0]      recip_prod;
  logic [30:0]      seed_rem;
  logic             mod_hit;
  logic [DIV_DW-1:0] fails_x100;
  logic             check_on;
  logic             rsp_load;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // ---------------- configuration ----------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable  <= 1'b0;
      prob_lo <= '0;
      prob_hi <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ENABLE:  enable  <= cfg_data[0];
        CFG_PROB_LO: prob_lo <= cfg_data;
        CFG_PROB_HI: prob_hi <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- point selection ----------------
  assign found = ({1'b0, idx_r} < 5'(NUM_POINTS));
  assign sel   = idx_r[IW-1:0];
  assign pct   = idx_r[3] ? prob_hi[7*idx_r[2:0] +: PCT_W] : prob_lo[7*idx_r[2:0] +: PCT_W];

  assign seed_rd  = found ? seeds[sel] : '0;
  assign calls_rd = found ? calls[sel] : '0;
  assign fails_rd = found ? fails[sel] : '0;

  assign seed_next  = lcg_next(seed_rd);
  assign recip_prod = 62'(lcg_val) * 62'(RECIP_100);
  assign seed_rem   = lcg_val - ({6'b0, mod_q} * 31'(PCT_BASE));
  assign mod_hit    = (seed_rem < 31'(pct));
  assign fails_x100 = {1'b0, fails_rd, 6'b0} + {2'b0, fails_rd, 5'b0} + {5'b0, fails_rd, 2'b0};
  assign check_on   = (mode_r == MODE_CHECK) && enable;

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_stall  = 1'b1;
    rsp_load   = 1'b0;
    div_req    = '0;
    case (state)
      S_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!found) begin
          state_next = S_DONE;
        end else if (check_on && (pct != '0)) begin
          state_next = S_LCG;
        end else begin
          state_next = S_RATE0;
        end
      end
      S_LCG: begin
        state_next = S_MOD;
      end
      S_MOD: begin
        state_next = S_RATE0;
      end
      S_RATE0: begin
        if (calls_rd == '0) begin
          state_next = S_DONE;
        end else begin
          div_req.start    = 1'b1;
          div_req.top      = RATE_TOP;
          div_req.dividend = fails_x100;
          div_req.divisor  = calls_rd;
          state_next       = S_RATE;
        end
      end
      S_RATE: begin
        if (div_rsp.done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  pfi_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // ---------------- request working registers ----------------
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      mode_r <= req_data.mode;
      idx_r  <= req_data.point_index;
      fail_r <= 1'b0;
      rate_r <= '0;
    end
    if (state == S_EXEC) begin
      lcg_val <= seed_next;
    end
    if (state == S_LCG) begin
      mod_q <= recip_prod[RECIP_SHIFT +: MOD_QW];
    end
    if (state == S_MOD && mod_hit) begin
      fail_r <= 1'b1;
    end
    if (state == S_RATE && div_rsp.done) begin
      rate_r <= (div_rsp.quotient > DIV_QW'(PCT_BASE)) ? PCT_W'(PCT_BASE)
                                                       : div_rsp.quotient[PCT_W-1:0];
    end
  end

  // ---------------- point table ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_POINTS; k++) begin
        seeds[k] <= seed_init(4'(k));
        calls[k] <= '0;
        fails[k] <= '0;
      end
    end else begin
      if (state == S_EXEC) begin
        if (mode_r == MODE_CLR_ALL) begin
          for (int k = 0; k < NUM_POINTS; k++) begin
            calls[k] <= '0;
            fails[k] <= '0;
          end
        end
        if (found) begin
          if (check_on) begin
            calls[sel] <= calls_rd + CNT_W'(1);
            if (pct != '0) begin
              seeds[sel] <= {1'b0, seed_next};
            end
          end else if (mode_r == MODE_CLR_ONE) begin
            calls[sel] <= '0;
            fails[sel] <= '0;
          end
        end
      end
      if (state == S_MOD && mod_hit) begin
        fails[sel] <= fails_rd + CNT_W'(1);
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      if (found) begin
        rsp_data.status            <= 1'b0;
        rsp_data.fail_now          <= fail_r;
        rsp_data.calls_seen        <= calls_rd;
        rsp_data.failures_seen     <= fails_rd;
        rsp_data.failure_rate      <= rate_r;
        rsp_data.point_probability <= pct;
        rsp_data.point_enabled     <= (pct != '0);
      end else begin
        rsp_data.status            <= 1'b1;
        rsp_data.fail_now          <= 1'b0;
        rsp_data.calls_seen        <= '0;
        rsp_data.failures_seen     <= '0;
        rsp_data.failure_rate      <= '0;
        rsp_data.point_probability <= '0;
        rsp_data.point_enabled     <= 1'b0;
      end
    end
  end

  // ---------------- assertions ----------------
  `PFI_ASSERT_NOW(a_rate_max, rsp_valid, rsp_data.failure_rate <= 7'd100, "failure rate above 100")
  `PFI_ASSERT_NOW(a_fail_point, rsp_valid && rsp_data.fail_now, rsp_data.point_enabled && !rsp_data.status, "fault on disabled or missing point")
  `PFI_ASSERT_NOW(a_nf_zero, rsp_valid && rsp_data.status, rsp_data.calls_seen == '0 && rsp_data.failures_seen == '0 && !rsp_data.fail_now, "not-found result carries data")
  `PFI_ASSERT_NOW(a_div_state, div_rsp.done, state == S_MOD || state == S_RATE, "divider finished outside a wait state")
  `PFI_ASSERT_NEXT(a_start_wait, div_req.start, state == S_MOD || state == S_RATE, "divider started without wait state")

endmodule

// File: sv/pfi_divider.sv
// Iterative restoring divider, one compare-subtract step per cycle.
module pfi_divider
  import pfi_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy;
  logic              done;
  logic [DIV_DW-1:0] rem;
  logic [DIV_DW-1:0] dvs;
  logic [DIV_QW-1:0] quo;
  logic [DIV_TW-1:0] cnt;
  logic              ge;

  assign ge = (rem >= dvs);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        rem  <= req.dividend;
        dvs  <= DIV_DW'(req.divisor) << req.top;
        quo  <= '0;
        cnt  <= req.top;
      end else if (busy) begin
        if (ge) begin
          rem <= rem - dvs;
        end
        quo <= {quo[DIV_QW-2:0], ge};
        dvs <= dvs >> 1;
        cnt <= cnt - DIV_TW'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// File: tb/tb_probabilistic_fault_injector.sv
// Self-checking testbench for the fault injector: directed table, then randomized phases.
module tb_probabilistic_fault_injector;
  import pfi_pkg::*;

  localparam int LIMIT_CYCLES  = 400000;
  localparam int DIRECTED_ROWS = 24;
  localparam int CFG_ROW       = 7;
  localparam int SEGMENTS      = 8;
  localparam int SEG_REQUESTS  = 60;
  localparam int DRAIN_CYCLES  = 60;

  // seeds of points 15 down to 0
  localparam logic [MAX_POINTS-1:0][31:0] RESET_SEEDS = {
    32'h01234567, 32'hF0123456, 32'hEF012345, 32'hDEF01234,
    32'hCDEF0123, 32'hBCDEF012, 32'hABCDEF01, 32'h9ABCDEF0,
    32'h89ABCDEF, 32'h789ABCDE, 32'h6789ABCD, 32'h56789ABC,
    32'h456789AB, 32'h3456789A, 32'h23456789, 32'h12345678
  };

  typedef struct packed {
    pfi_in_t  req;
    logic     known;
    pfi_out_t want;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  pfi_in_t     req_data = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  pfi_out_t    rsp_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_ENABLE;
  logic [55:0] cfg_data = '0;

  // predictor state
  logic [31:0] seed_state [MAX_POINTS];
  logic [31:0] call_count [MAX_POINTS];
  logic [31:0] fail_count [MAX_POINTS];
  logic        model_enable;
  logic [55:0] model_prob_lo;
  logic [55:0] model_prob_hi;

  pfi_out_t      expected_rsp [$];
  directed_row_t directed_rows [DIRECTED_ROWS];
  int            mismatches = 0;
  int            cycle_count = 0;
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;

  probabilistic_fault_injector dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("[probabilistic_fault_injector] ERROR");
      $finish;
    end
  end

  function automatic pfi_out_t injector_outcome(input pfi_in_t req);
    pfi_out_t    r;
    logic [3:0]  idx;
    logic [6:0]  pct;
    logic [63:0] prod;
    logic [63:0] ratio;
    int          k;
    r = '0;
    idx = req.point_index;
    if (req.mode == MODE_CLR_ALL)
      for (k = 0; k < PFI_NUM_POINTS; k++) begin
        call_count[k] = '0;
        fail_count[k] = '0;
      end
    if (idx >= PFI_NUM_POINTS) begin
      r.status = 1'b1;
      return r;
    end
    pct = (idx < 4'd8) ? model_prob_lo[7*idx[2:0] +: PCT_W] : model_prob_hi[7*idx[2:0] +: PCT_W];
    if (req.mode == MODE_CHECK && model_enable) begin
      call_count[idx] = call_count[idx] + 32'd1;
      if (pct != '0) begin
        prod = 64'(seed_state[idx]) * 64'(LCG_MUL) + 64'(LCG_ADD);
        seed_state[idx] = {1'b0, prod[30:0]};
        if ((seed_state[idx] % 32'(PCT_BASE)) < 32'(pct)) begin
          r.fail_now = 1'b1;
          fail_count[idx] = fail_count[idx] + 32'd1;
        end
      end
    end else if (req.mode == MODE_CLR_ONE) begin
      call_count[idx] = '0;
      fail_count[idx] = '0;
    end
    if (call_count[idx] != '0) begin
      ratio = (64'(fail_count[idx]) * 64'(PCT_BASE)) / 64'(call_count[idx]);
      r.failure_rate = (ratio > 64'(PCT_BASE)) ? 7'(PCT_BASE) : ratio[6:0];
    end
    r.calls_seen        = call_count[idx];
    r.failures_seen     = fail_count[idx];
    r.point_probability = pct;
    r.point_enabled     = (pct != '0);
    return r;
  endfunction

  function automatic pfi_out_t result_of(input logic st, input logic fail, input logic [31:0] calls,
                                         input logic [31:0] fails, input logic [6:0] rate,
                                         input logic [6:0] prob, input logic en);
    pfi_out_t r;
    r = '{st, fail, calls, fails, rate, prob, en};
    return r;
  endfunction

  function automatic directed_row_t typed(input logic [1:0] m, input logic [3:0] i,
                                          input pfi_out_t w);
    directed_row_t row;
    row.req   = '{m, i};
    row.known = 1'b1;
    row.want  = w;
    return row;
  endfunction

  function automatic directed_row_t predicted(input logic [1:0] m, input logic [3:0] i);
    directed_row_t row;
    row.req   = '{m, i};
    row.known = 1'b0;
    row.want  = '0;
    return row;
  endfunction

  // each 7-bit field: zero, always-fail or a real percentage
  function automatic logic [55:0] random_prob_word();
    logic [55:0] w;
    int          f;
    int unsigned pick;
    w = '0;
    for (f = 0; f < 8; f++) begin
      pick = $urandom_range(99);
      if (pick < 20)
        w[7*f +: 7] = 7'd0;
      else if (pick < 35)
        w[7*f +: 7] = 7'($urandom_range(127, 100));
      else
        w[7*f +: 7] = 7'($urandom_range(99, 1));
    end
    return w;
  endfunction

  function automatic pfi_in_t random_req();
    pfi_in_t     r;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 62)
      r.mode = MODE_CHECK;
    else if (pick < 84)
      r.mode = MODE_STATS;
    else if (pick < 96)
      r.mode = MODE_CLR_ONE;
    else
      r.mode = MODE_CLR_ALL;
    if ($urandom_range(99) < 88)
      r.point_index = 4'($urandom_range(PFI_NUM_POINTS - 1));
    else
      r.point_index = 4'($urandom_range(15, PFI_NUM_POINTS));
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // receiver: random stall and response check
  always @(posedge clk) begin
    pfi_out_t want;
    rsp_stall <= ($urandom_range(99) < recv_stall_pct);
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsp.size() == 0) begin
        $error("response with no request pending");
        mismatches++;
      end else begin
        want = expected_rsp.pop_front();
        check_field("status", 32'(want.status), 32'(rsp_data.status));
        check_field("fail_now", 32'(want.fail_now), 32'(rsp_data.fail_now));
        check_field("calls_seen", want.calls_seen, rsp_data.calls_seen);
        check_field("failures_seen", want.failures_seen, rsp_data.failures_seen);
        check_field("failure_rate", 32'(want.failure_rate), 32'(rsp_data.failure_rate));
        check_field("point_probability", 32'(want.point_probability),
                    32'(rsp_data.point_probability));
        check_field("point_enabled", 32'(want.point_enabled), 32'(rsp_data.point_enabled));
      end
    end
  end

  task automatic send_request(input pfi_in_t req, input logic known, input pfi_out_t want);
    int       gap;
    pfi_out_t outcome;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct)
      gap++;
    if (send_idle_pct != 0 && $urandom_range(7) == 0)
      gap += $urandom_range(40);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= req;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    outcome = injector_outcome(req);
    expected_rsp.push_back(known ? want : outcome);
  endtask

  task automatic wait_idle();
    req_valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [55:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_ENABLE:  model_enable = value[0];
      CFG_PROB_LO: model_prob_lo = value;
      CFG_PROB_HI: model_prob_hi = value;
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic en, input logic [55:0] lo, input logic [55:0] hi);
    write_reg(CFG_ENABLE, 56'(en));
    write_reg(CFG_PROB_LO, lo);
    write_reg(CFG_PROB_HI, hi);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int          i;
    int          seg;
    int          n;
    logic        en;
    logic [55:0] lo;
    logic [55:0] hi;
    pfi_out_t    none_found;
    pfi_out_t    all_zero;

    for (i = 0; i < MAX_POINTS; i++) begin
      seed_state[i] = RESET_SEEDS[i];
      call_count[i] = '0;
      fail_count[i] = '0;
    end
    model_enable  = 1'b0;
    model_prob_lo = '0;
    model_prob_hi = '0;

    none_found = result_of(1'b1, 1'b0, 32'd0, 32'd0, 7'd0, 7'd0, 1'b0);
    all_zero   = result_of(1'b0, 1'b0, 32'd0, 32'd0, 7'd0, 7'd0, 1'b0);
    directed_rows = '{
      // reset settings: subsystem off, every point disabled
      typed(MODE_STATS, 4'd0, all_zero),
      typed(MODE_CHECK, 4'd0, all_zero),
      typed(MODE_CHECK, 4'd11, all_zero),
      typed(MODE_STATS, 4'd12, none_found),
      typed(MODE_CHECK, 4'd15, none_found),
      typed(MODE_CLR_ONE, 4'd13, none_found),
      typed(MODE_CLR_ALL, 4'd14, none_found),
      // enabled, mixed percentages
      typed(MODE_CHECK, 4'd0, result_of(1'b0, 1'b1, 32'd1, 32'd1, 7'd100, 7'd127, 1'b1)),
      typed(MODE_CHECK, 4'd1, result_of(1'b0, 1'b0, 32'd1, 32'd0, 7'd0, 7'd0, 1'b0)),
      typed(MODE_CHECK, 4'd3, result_of(1'b0, 1'b1, 32'd1, 32'd1, 7'd100, 7'd100, 1'b1)),
      predicted(MODE_CHECK, 4'd2),
      predicted(MODE_CHECK, 4'd2),
      predicted(MODE_CHECK, 4'd4),
      predicted(MODE_CHECK, 4'd5),
      predicted(MODE_CHECK, 4'd11),
      typed(MODE_CHECK, 4'd11, result_of(1'b0, 1'b1, 32'd2, 32'd2, 7'd100, 7'd127, 1'b1)),
      predicted(MODE_STATS, 4'd2),
      typed(MODE_CLR_ONE, 4'd0, result_of(1'b0, 1'b0, 32'd0, 32'd0, 7'd0, 7'd127, 1'b1)),
      predicted(MODE_CHECK, 4'd8),
      predicted(MODE_CHECK, 4'd10),
      typed(MODE_CLR_ALL, 4'd12, none_found),
      typed(MODE_STATS, 4'd11, result_of(1'b0, 1'b0, 32'd0, 32'd0, 7'd0, 7'd127, 1'b1)),
      typed(MODE_STATS, 4'd3, result_of(1'b0, 1'b0, 32'd0, 32'd0, 7'd0, 7'd100, 1'b1)),
      typed(MODE_CHECK, 4'd12, none_found)
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < DIRECTED_ROWS; i++) begin
      if (i == CFG_ROW) begin
        wait_idle();
        // points 7..0: 0, 64, 99, 1, 100, 50, 0, 127
        lo = {7'd0, 7'd64, 7'd99, 7'd1, 7'd100, 7'd50, 7'd0, 7'd127};
        // points 15..8: out of range ones at 127, then 127, 99, 0, 1
        hi = {7'd127, 7'd127, 7'd127, 7'd127, 7'd127, 7'd99, 7'd0, 7'd1};
        load_settings(1'b1, lo, hi);
      end
      send_request(directed_rows[i].req, directed_rows[i].known, directed_rows[i].want);
    end

    for (seg = 0; seg < SEGMENTS; seg++) begin
      wait_idle();
      case (seg % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      en = 1'b1;
      lo = random_prob_word();
      hi = random_prob_word();
      case (seg)
        1: begin lo = '1; hi = '1; end
        2: en = 1'b0;
        3: begin lo = '0; hi = '0; end
        5: begin lo = 56'({$urandom, $urandom}); hi = 56'({$urandom, $urandom}); end
        default: ;
      endcase
      load_settings(en, lo, hi);
      for (n = 0; n < SEG_REQUESTS; n++)
        send_request(random_req(), 1'b0, '0);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("[probabilistic_fault_injector] OK");
    else
      $display("[probabilistic_fault_injector] ERROR");
    $finish;
  end

endmodule
